/* rtl/core/sfv_pkg.sv */
package sfv_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_LETTERS = 4'd1,
    PH_BAR     = 4'd2,
    PH_BODY    = 4'd3,
    PH_DIGITS  = 4'd4,
    PH_SEMI    = 4'd5,
    PH_DONE    = 4'd6
  } phase_t;

  localparam logic [7:0] CH_START = 8'h7E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [31:0] WORD_ONE   = 32'h4E45494C;
  localparam logic [31:0] WORD_TWO   = 32'h4E554E4F;
  localparam logic [31:0] WORD_THREE = 32'h49534D41;

  localparam logic [1:0] CODE_UNKNOWN = 2'd0;
  localparam logic [1:0] CODE_ONE     = 2'd1;
  localparam logic [1:0] CODE_TWO     = 2'd2;
  localparam logic [1:0] CODE_THREE   = 2'd3;

  localparam logic [2:0] LETTER_COUNT = 3'd4;
  localparam logic [2:0] DIGIT_COUNT  = 3'd3;
  localparam logic [3:0] COMMA_MAX    = 4'd15;
  localparam logic [3:0] COMMA_SAT    = 4'd14;
  localparam logic [3:0] FIELD_MAX    = 4'd15;
  localparam logic [3:0] FIELD_BIAS   = 4'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       well_formed;
    logic [1:0] format_code;
    logic [3:0] field_total;
    logic       count_matches;
  } result_t;

  typedef struct packed {
    logic     valid;
    logic     step;
    in_item_t item;
  } stage_ctrl_t;

endpackage

/* rtl/core/sfv_stream_if.sv */
interface sfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface sfv_out_if;
  logic       valid;
  logic       ready;
  logic       well_formed;
  logic [1:0] format_code;
  logic [3:0] field_total;
  logic       count_matches;

  modport source (output valid, output well_formed, output format_code,
                  output field_total, output count_matches, input ready);
  modport sink   (input valid, input well_formed, input format_code,
                  input field_total, input count_matches, output ready);
endinterface

/* rtl/core/sfv_in_stage.sv */
module sfv_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  sfv_in_if.sink             in_ch,
  input  logic               advance,
  output sfv_pkg::in_item_t  item,
  output logic               item_valid
);
  import sfv_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.char_byte <= in_ch.char_byte;
      item_r.is_last   <= in_ch.is_last;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;
endmodule

/* rtl/core/sfv_parser.sv */
module sfv_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfv_pkg::stage_ctrl_t ctrl,
  output sfv_pkg::result_t     result
);
  import sfv_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [31:0] letters_r, letters_nxt;
  logic [3:0]  comma_r, comma_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  c;
  logic        is_upper, is_lower, is_digit;
  logic [7:0]  up_c;
  logic [2:0]  pos_inc;
  logic        ok;
  logic [1:0]  code;
  logic [3:0]  total;

  assign c        = ctrl.item.char_byte;
  assign is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
  assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign up_c     = is_lower ? (c - CASE_GAP) : c;
  assign pos_inc  = pos_r + 3'd1;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    letters_nxt = letters_r;
    comma_nxt   = comma_r;
    err_nxt     = err_r;
    if (!err_r) begin
      case (phase_r)
        PH_START: begin
          if (c == CH_START) begin
            phase_nxt = PH_LETTERS;
            pos_nxt   = 3'd0;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_LETTERS: begin
          if (is_upper || is_lower) begin
            letters_nxt = {letters_r[23:0], up_c};
            pos_nxt     = pos_inc;
            if (pos_inc >= LETTER_COUNT) begin
              phase_nxt = PH_BAR;
              pos_nxt   = 3'd0;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_BAR: begin
          if (c == CH_BAR) begin
            phase_nxt = PH_BODY;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_BODY: begin
          if (c == CH_START || c == CH_SEMI) begin
            err_nxt = 1'b1;
          end else if (c == CH_BAR) begin
            phase_nxt = PH_DIGITS;
            pos_nxt   = 3'd0;
          end else if (c == CH_COMMA && comma_r < COMMA_MAX) begin
            comma_nxt = comma_r + 4'd1;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            pos_nxt = pos_inc;
            if (pos_inc >= DIGIT_COUNT) begin
              phase_nxt = PH_SEMI;
              pos_nxt   = 3'd0;
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_SEMI: begin
          if (c == CH_SEMI) begin
            phase_nxt = PH_DONE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    ok    = !err_nxt && (phase_nxt == PH_DONE);
    code  = CODE_UNKNOWN;
    total = 4'd0;
    if (ok) begin
      if (letters_nxt == WORD_ONE) begin
        code = CODE_ONE;
      end else if (letters_nxt == WORD_TWO) begin
        code = CODE_TWO;
      end else if (letters_nxt == WORD_THREE) begin
        code = CODE_THREE;
      end
      total = (comma_nxt >= COMMA_SAT) ? FIELD_MAX : (comma_nxt + 4'd1);
    end
    result.well_formed   = ok;
    result.format_code   = code;
    result.field_total   = total;
    result.count_matches = ok && (code != CODE_UNKNOWN) &&
                           (total == ({2'b00, code} + FIELD_BIAS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      pos_r     <= 3'd0;
      letters_r <= 32'd0;
      comma_r   <= 4'd0;
      err_r     <= 1'b0;
    end else if (ctrl.step) begin
      if (ctrl.item.is_last) begin
        phase_r   <= PH_START;
        pos_r     <= 3'd0;
        letters_r <= 32'd0;
        comma_r   <= 4'd0;
        err_r     <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        letters_r <= letters_nxt;
        comma_r   <= comma_nxt;
        err_r     <= err_nxt;
      end
    end
  end
endmodule

/* rtl/core/sfv_out_stage.sv */
module sfv_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfv_pkg::result_t result,
  output logic             busy,
  sfv_out_if.source        out_ch
);
  import sfv_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign busy = valid_r && !out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.well_formed   = res_r.well_formed;
  assign out_ch.format_code   = res_r.format_code;
  assign out_ch.field_total   = res_r.field_total;
  assign out_ch.count_matches = res_r.count_matches;
endmodule

/* rtl/core/sentence_format_validator.sv */
// Sentence checker that takes one byte per cycle on in_ch and delivers one
// verdict on out_ch per sentence. Each byte goes through an input register
// and then a single parser update; the final byte's update writes the verdict
// to the result register, from which it is offered on out_ch. Bytes stream at
// one per cycle; the only stall is a final byte held in the input register
// while the previous verdict still waits to be taken on out_ch.
module sentence_format_validator (
  input  logic      clk,
  input  logic      rst_n,
  sfv_in_if.sink    in_ch,
  sfv_out_if.source out_ch
);
  import sfv_pkg::*;

  in_item_t    item;
  logic        item_valid;
  logic        advance;
  logic        out_busy;
  stage_ctrl_t ctrl;
  result_t     result;

  assign advance = item_valid && !(item.is_last && out_busy);

  assign ctrl.valid = item_valid;
  assign ctrl.step  = advance;
  assign ctrl.item  = item;

  sfv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  sfv_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .result (result)
  );

  sfv_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (ctrl.valid && ctrl.step && ctrl.item.is_last),
    .result (result),
    .busy   (out_busy),
    .out_ch (out_ch)
  );
endmodule
